@@ hdl/length_checksum_frame_receiver_core_defines.svh @@
// assertion macros for the length and checksum frame receiver
`ifndef LENGTH_CHECKSUM_FRAME_RECEIVER_CORE_DEFINES_SVH
`define LENGTH_CHECKSUM_FRAME_RECEIVER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LCFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lcfr_pkg.sv @@
// types and constants of the length and checksum frame receiver
package lcfr_pkg;

  // uart event codes
  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_ERROR = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_START_BYTE    = 2'd0,
    REG_MAX_SIZE      = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2,
    REG_OFFLINE_TICKS = 2'd3
  } reg_e;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0] START_BYTE_RST    = 8'd2;
  localparam logic [7:0] MAX_SIZE_RST      = 8'd32;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd10;
  localparam logic [7:0] OFFLINE_TICKS_RST = 8'd100;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  // one result item
  typedef struct packed {
    logic [7:0] byte_out;
    logic [8:0] byte_position;
    logic       body_byte;
    logic       frame_done;
    logic       frame_valid;
    logic       frame_dropped;
    logic       receiving;
    logic       comm_offline;
  } result_t;

endpackage

@@ hdl/length_checksum_frame_receiver_core.sv @@
// Length-prefixed frame receiver with two's complement checksum. Each input transfer is one
// UART event (byte, line error or timer tick) and yields exactly one result transfer. An
// input register takes the event, a single pass of logic updates the frame state and forms
// the result, and a result register holds it for the output side: one item per clock cycle
// sustained while the output side takes each result. Input stays ready while the
// result register is full as long as the input register is free or the result is taken in
// the same cycle. Configuration registers sit on an APB-style port at byte addresses 0, 4,
// 8 and 12 (start byte, max size, timeout ticks, offline ticks); write them only while idle.
`include "length_checksum_frame_receiver_core_defines.svh"

module length_checksum_frame_receiver_core
  import lcfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // event input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         rx_byte_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         byte_out_o,
  output logic [8:0]         byte_position_o,
  output logic               body_byte_o,
  output logic               frame_done_o,
  output logic               frame_valid_o,
  output logic               frame_dropped_o,
  output logic               receiving_o,
  output logic               comm_offline_o
);

  // configuration registers
  logic [7:0] start_byte_q, max_size_q, timeout_ticks_q, offline_ticks_q;
  reg_e       reg_idx;
  logic       cfg_wr;

  // input register
  logic       s1_valid_q;
  action_e    s1_action_q;
  logic [7:0] s1_byte_q;

  // frame state
  logic [8:0] pos_q, pos_d, pos_cur;
  logic [7:0] size_q, size_d, cur_size;
  logic [7:0] sum_q, sum_d, want;
  logic [7:0] idle_q, idle_d;
  logic [7:0] cnt_q, cnt_d;
  logic       flag_q, flag_d;

  // result register
  logic       out_valid_q;
  result_t    res_q, res_d;

  logic       in_fire, out_load, s1_adv;

  assign reg_idx = reg_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q    <= START_BYTE_RST;
      max_size_q      <= MAX_SIZE_RST;
      timeout_ticks_q <= TIMEOUT_TICKS_RST;
      offline_ticks_q <= OFFLINE_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_BYTE:    start_byte_q    <= pwdata[7:0];
        REG_MAX_SIZE:      max_size_q      <= pwdata[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks_q <= pwdata[7:0];
        REG_OFFLINE_TICKS: offline_ticks_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_START_BYTE:    prdata[7:0] = start_byte_q;
      REG_MAX_SIZE:      prdata[7:0] = max_size_q;
      REG_TIMEOUT_TICKS: prdata[7:0] = timeout_ticks_q;
      REG_OFFLINE_TICKS: prdata[7:0] = offline_ticks_q;
      default: ;
    endcase
  end

  // pipeline handshake
  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_e'(action_i);
      s1_byte_q   <= rx_byte_i;
    end
  end

  // single pass state update and result
  always_comb begin
    idle_d   = idle_q;
    cnt_d    = cnt_q;
    size_d   = size_q;
    sum_d    = sum_q;
    flag_d   = flag_q;
    res_d    = '0;
    pos_cur  = pos_q;
    cur_size = size_q;
    want     = ~sum_q + 8'd1;

    // tick ages both counters, saturating
    if (s1_action_q == ACT_TICK) begin
      if (idle_q != CNT_MAX) idle_d = idle_q + 8'd1;
      if (cnt_q != CNT_MAX)  cnt_d  = cnt_q + 8'd1;
    end

    // inactivity timeout abandons a frame in progress
    if (pos_q != '0 && idle_d >= timeout_ticks_q) begin
      pos_cur             = '0;
      res_d.frame_dropped = 1'b1;
    end
    pos_d = pos_cur;

    case (s1_action_q)
      ACT_ERROR: begin
        pos_d               = '0;
        res_d.frame_dropped = 1'b1;
      end
      ACT_BYTE: begin
        res_d.byte_out      = s1_byte_q;
        res_d.byte_position = pos_cur;
        idle_d              = '0;
        pos_d               = 9'(pos_cur + 9'd1);
        if (pos_cur == '0) begin
          // hunting for the start byte
          if (s1_byte_q == start_byte_q) begin
            sum_d = s1_byte_q;
          end else begin
            pos_d               = '0;
            res_d.frame_dropped = 1'b1;
          end
        end else begin
          if (pos_cur == 9'd1) begin
            cur_size = s1_byte_q;
            size_d   = s1_byte_q;
          end
          if (pos_cur >= ({1'b0, cur_size} + 9'd1)) begin
            // closing checksum byte
            res_d.frame_done = 1'b1;
            pos_d            = '0;
            if (want == s1_byte_q) begin
              res_d.frame_valid = 1'b1;
              cnt_d             = '0;
              flag_d            = 1'b0;
            end
          end else begin
            sum_d = sum_q + s1_byte_q;
            if (pos_cur == 9'd1 && s1_byte_q > max_size_q) begin
              pos_d               = '0;
              res_d.frame_dropped = 1'b1;
            end else begin
              res_d.body_byte = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // offline limit
    if (cnt_d >= offline_ticks_q) flag_d = 1'b1;

    res_d.receiving    = (pos_d != '0);
    res_d.comm_offline = flag_d;
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      size_q <= '0;
      sum_q  <= '0;
      idle_q <= '0;
      cnt_q  <= '0;
      flag_q <= 1'b0;
    end else if (s1_adv) begin
      pos_q  <= pos_d;
      size_q <= size_d;
      sum_q  <= sum_d;
      idle_q <= idle_d;
      cnt_q  <= cnt_d;
      flag_q <= flag_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_out_o      = res_q.byte_out;
  assign byte_position_o = res_q.byte_position;
  assign body_byte_o     = res_q.body_byte;
  assign frame_done_o    = res_q.frame_done;
  assign frame_valid_o   = res_q.frame_valid;
  assign frame_dropped_o = res_q.frame_dropped;
  assign receiving_o     = res_q.receiving;
  assign comm_offline_o  = res_q.comm_offline;

  // checks
  `LCFR_ASSERT_NEXT(a_done_returns_to_hunt, clk_i, rst_ni,
                    s1_adv && res_d.frame_done, pos_q == '0,
                    "frame end did not return to hunting")
  // a timed-out frame may be followed by a new start byte in the same item
  `LCFR_ASSERT_NEXT(a_drop_returns_to_hunt, clk_i, rst_ni,
                    s1_adv && res_d.frame_dropped && s1_action_q != ACT_BYTE, pos_q == '0,
                    "dropped frame left position set")
  `LCFR_ASSERT_NEXT(a_good_frame_clears_count, clk_i, rst_ni,
                    s1_adv && res_d.frame_valid, cnt_q == '0,
                    "good frame did not clear offline count")
  `LCFR_ASSERT_SAME(a_position_bound, clk_i, rst_ni, 1'b1, pos_q <= 9'd256,
                    "frame position out of range")

endmodule
